// File: rtl/core/frb_pkg.sv
// frb_pkg: sizes, codes and shared types of the frame ring buffer.
// Used by frb_ptr_add, frb_ctrl and frame_ring_buffer; no dependencies.
package frb_pkg;

    localparam int RING_BYTES  = 256;
    localparam int FRAME_BYTES = 12;

    localparam int PTR_W   = $clog2(RING_BYTES);
    localparam int OFS_W   = $clog2(FRAME_BYTES + 1);
    localparam int CNT_W   = (FRAME_BYTES > 2) ? $clog2(FRAME_BYTES) : 1;
    localparam int FRAME_W = FRAME_BYTES * 8;

    localparam int PADDR_W = 2;
    localparam logic [PADDR_W-1:0] CFG_START_BYTE_ADDR = 2'd0;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_PULL = 1'b1;

    typedef enum logic [2:0] {
        ST_PUSH_OK    = 3'd0,
        ST_PUSH_FULL  = 3'd1,
        ST_PULL_EMPTY = 3'd2,
        ST_PULL_NOHDR = 3'd3,
        ST_BYTE       = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_WR,
        S_PUSH_ADV,
        S_PULL_H0,
        S_PULL_H1,
        S_PULL_CHK,
        S_PULL_OUT,
        S_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [PTR_W-1:0] addr;
        logic [7:0]       wdata;
    } ram_req_t;

    typedef struct packed {
        logic       valid;
        status_t    status;
        logic [7:0] data;
        logic       last;
    } res_t;

endpackage

// File: rtl/core/frb_ram.sv
// frb_ram: generic single-port RAM, one write and one registered read a cycle at one address.
// Standalone; no package dependencies.
module frb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/frb_ptr_add.sv
// frb_ptr_add: shared ring index adder, base + offset wrapped at the ring size.
// Depends on frb_pkg.
module frb_ptr_add (
    input  logic [frb_pkg::PTR_W-1:0] base,
    input  logic [frb_pkg::OFS_W-1:0] ofs,
    output logic [frb_pkg::PTR_W-1:0] sum
);

    logic [frb_pkg::PTR_W:0] raw;

    always_comb
    begin
        raw = {1'b0, base} + (frb_pkg::PTR_W + 1)'(ofs);
        if (raw >= (frb_pkg::PTR_W + 1)'(frb_pkg::RING_BYTES))
        begin
            raw = raw - (frb_pkg::PTR_W + 1)'(frb_pkg::RING_BYTES);
        end
        sum = raw[frb_pkg::PTR_W-1:0];
    end

endmodule

// File: rtl/core/frb_ctrl.sv
// frb_ctrl: sequencer for push and pull, head/tail pointers, ring RAM requests.
// Depends on frb_pkg and frb_ptr_add.
module frb_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic                        action,
    input  logic [63:0]                 frame_lo,
    input  logic [31:0]                 frame_hi,
    input  logic [7:0]                  start_byte,
    output frb_pkg::res_t               res,
    input  logic                        res_ready,
    output frb_pkg::ram_req_t           ram_req,
    input  logic [7:0]                  ram_rdata
);

    frb_pkg::ctrl_state_t          state_reg, state_next;
    logic [frb_pkg::PTR_W-1:0]     head_reg, head_next;
    logic [frb_pkg::PTR_W-1:0]     tail_reg, tail_next;
    logic [frb_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [frb_pkg::FRAME_W-1:0]   frame_reg, frame_next;
    frb_pkg::status_t              status_reg, status_next;
    logic                          hdr_ok_reg, hdr_ok_next;

    logic [frb_pkg::PTR_W-1:0]     add_base;
    logic [frb_pkg::OFS_W-1:0]     add_ofs;
    logic [frb_pkg::PTR_W-1:0]     add_sum;
    logic [frb_pkg::PTR_W:0]       free_bytes;
    logic                          empty;
    logic                          push_ok;
    logic                          cnt_last;
    logic                          hdr_match;

    frb_ptr_add u_add (
        .base (add_base),
        .ofs  (add_ofs),
        .sum  (add_sum)
    );

    assign empty = (head_reg == tail_reg);

    always_comb
    begin
        if (head_reg >= tail_reg)
        begin
            free_bytes = {1'b0, head_reg} - {1'b0, tail_reg};
        end
        else
        begin
            free_bytes = {1'b0, head_reg}
                       + (frb_pkg::PTR_W + 1)'(frb_pkg::RING_BYTES)
                       - {1'b0, tail_reg};
        end
    end

    assign push_ok   = empty ||
                       (free_bytes > (frb_pkg::PTR_W + 1)'(frb_pkg::FRAME_BYTES + 1));
    assign cnt_last  = (cnt_reg == frb_pkg::CNT_W'(frb_pkg::FRAME_BYTES - 1));
    assign hdr_match = hdr_ok_reg && (ram_rdata == start_byte);
    assign item_ready = (state_reg == frb_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= frb_pkg::S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            cnt_reg    <= '0;
            status_reg <= frb_pkg::ST_PUSH_OK;
            hdr_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
            hdr_ok_reg <= hdr_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frb_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    if (action == frb_pkg::ACT_PULL)
                    begin
                        state_next = empty ? frb_pkg::S_RESULT : frb_pkg::S_PULL_H0;
                    end
                    else
                    begin
                        state_next = push_ok ? frb_pkg::S_PUSH_WR : frb_pkg::S_RESULT;
                    end
                end
            end
            frb_pkg::S_PUSH_WR:
            begin
                if (cnt_last)
                begin
                    state_next = frb_pkg::S_PUSH_ADV;
                end
            end
            frb_pkg::S_PUSH_ADV: state_next = frb_pkg::S_RESULT;
            frb_pkg::S_PULL_H0:  state_next = frb_pkg::S_PULL_H1;
            frb_pkg::S_PULL_H1:  state_next = frb_pkg::S_PULL_CHK;
            frb_pkg::S_PULL_CHK:
            begin
                state_next = hdr_match ? frb_pkg::S_PULL_OUT : frb_pkg::S_RESULT;
            end
            frb_pkg::S_PULL_OUT:
            begin
                if (res_ready && cnt_last)
                begin
                    state_next = frb_pkg::S_IDLE;
                end
            end
            frb_pkg::S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = frb_pkg::S_IDLE;
                end
            end
            default: state_next = frb_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        frame_next  = frame_reg;
        status_next = status_reg;
        hdr_ok_next = hdr_ok_reg;
        add_base    = head_reg;
        add_ofs     = '0;
        ram_req     = '{we: 1'b0, re: 1'b0, addr: add_sum, wdata: frame_reg[7:0]};
        res         = '{valid: 1'b0, status: status_reg, data: 8'd0, last: 1'b1};

        unique case (state_reg)
            frb_pkg::S_IDLE:
            begin
                cnt_next   = '0;
                frame_next = frb_pkg::FRAME_W'({frame_hi, frame_lo});
                if (item_valid)
                begin
                    if (action == frb_pkg::ACT_PULL)
                    begin
                        status_next = frb_pkg::ST_PULL_EMPTY;
                    end
                    else
                    begin
                        status_next = frb_pkg::ST_PUSH_FULL;
                    end
                end
            end
            frb_pkg::S_PUSH_WR:
            begin
                add_base   = tail_reg;
                add_ofs    = frb_pkg::OFS_W'(cnt_reg);
                ram_req.we = 1'b1;
                frame_next = frame_reg >> 8;
                cnt_next   = cnt_reg + 1'b1;
            end
            frb_pkg::S_PUSH_ADV:
            begin
                add_base    = tail_reg;
                add_ofs     = frb_pkg::OFS_W'(frb_pkg::FRAME_BYTES);
                tail_next   = add_sum;
                status_next = frb_pkg::ST_PUSH_OK;
            end
            frb_pkg::S_PULL_H0:
            begin
                ram_req.re = 1'b1;
            end
            frb_pkg::S_PULL_H1:
            begin
                add_ofs     = frb_pkg::OFS_W'(1);
                ram_req.re  = 1'b1;
                hdr_ok_next = (ram_rdata == start_byte);
            end
            frb_pkg::S_PULL_CHK:
            begin
                cnt_next    = '0;
                status_next = frb_pkg::ST_PULL_NOHDR;
                ram_req.re  = hdr_match;
            end
            frb_pkg::S_PULL_OUT:
            begin
                add_ofs    = frb_pkg::OFS_W'(cnt_reg) + 1'b1;
                res.valid  = 1'b1;
                res.status = frb_pkg::ST_BYTE;
                res.data   = ram_rdata;
                res.last   = cnt_last;
                if (res_ready)
                begin
                    if (cnt_last)
                    begin
                        head_next = add_sum;
                    end
                    else
                    begin
                        ram_req.re = 1'b1;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                end
            end
            frb_pkg::S_RESULT:
            begin
                res.valid = 1'b1;
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_ram_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.we && ram_req.re))
        else $error("ring RAM read and write in the same cycle");

    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |-> !res.valid)
        else $error("beat accepted while a result is pending");

    a_tail_moves_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg != $past(tail_reg)) |-> ($past(state_reg) == frb_pkg::S_PUSH_ADV))
        else $error("tail moved outside push completion");

    a_head_moves_on_pull: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != $past(head_reg)) |->
            ($past(state_reg) == frb_pkg::S_PULL_OUT && $past(res_ready) && $past(cnt_last)))
        else $error("head moved outside final pulled byte");
`endif

endmodule

// File: rtl/core/frame_ring_buffer.sv
// Frame ring buffer: a 256-byte ring of whole 12-byte frames, one RAM byte moved per
// cycle, while the output side does not stall, through a single shared index adder. A
// push occupies the block for a decode step, the writes of its 12 bytes and a tail
// update, plus the wait for its status beat. A pull reads and checks two header bytes,
// then gives one result beat per cycle while the output side does not stall, 12 beats
// for a frame; a refused pull or push gives one status beat. The next item is taken
// once the last beat of the current one has entered the output register. start_byte
// sits at APB address 0. Depends on frb_pkg, frb_ram, frb_ptr_add and frb_ctrl.
module frame_ring_buffer (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [frb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        action,
    input  logic [63:0]                 frame_lo,
    input  logic [31:0]                 frame_hi,

    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [2:0]                  status,
    output logic [7:0]                  data_byte,
    output logic                        last
);

    logic [7:0]        start_byte_reg;
    logic              item_ready;
    frb_pkg::res_t     res;
    logic              res_ready;
    frb_pkg::ram_req_t ram_req;
    logic [7:0]        ram_rdata;

    logic              out_valid_reg;
    logic [2:0]        out_status_reg;
    logic [7:0]        out_data_reg;
    logic              out_last_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= 8'd0;
        end
        else if (psel && penable && pwrite && (paddr == frb_pkg::CFG_START_BYTE_ADDR))
        begin
            start_byte_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr == frb_pkg::CFG_START_BYTE_ADDR) ? {24'd0, start_byte_reg} : 32'd0;

    frb_ram #(
        .WIDTH (8),
        .DEPTH (frb_pkg::RING_BYTES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    frb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .action     (action),
        .frame_lo   (frame_lo),
        .frame_hi   (frame_hi),
        .start_byte (start_byte_reg),
        .res        (res),
        .res_ready  (res_ready),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    assign item_stall = !item_ready;

    // output beat register
    assign res_ready = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            out_status_reg <= res.status;
            out_data_reg   <= res.data;
            out_last_reg   <= res.last;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign data_byte    = out_data_reg;
    assign last         = out_last_reg;

endmodule

// File: sim/tb_frame_ring_buffer.sv
// Self-checking testbench for frame_ring_buffer: pushes and pulls 12-byte frames under
// random idling, predicts every result beat, and reprograms start_byte between phases.
// Depends on frb_pkg and the frame_ring_buffer RTL.
`timescale 1ns / 1ps

module tb_frame_ring_buffer;

    localparam int STUCK_LIMIT = 5000;
    localparam int PHASES      = 5;

    typedef struct packed {
        logic        act;
        logic [63:0] lo;
        logic [31:0] hi;
    } frame_cmd_t;

    typedef struct packed {
        frb_pkg::status_t st;
        logic [7:0]       db;
        logic             last;
    } beat_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [frb_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        item_valid;
    logic                        item_stall;
    logic                        action;
    logic [63:0]                 frame_lo;
    logic [31:0]                 frame_hi;
    logic                        result_valid;
    logic                        result_stall;
    logic [2:0]                  status;
    logic [7:0]                  data_byte;
    logic                        last;

    frame_ring_buffer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .frame_lo     (frame_lo),
        .frame_hi     (frame_hi),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .data_byte    (data_byte),
        .last         (last)
    );

    // ring image and start byte as the block should hold them
    logic [7:0]  ring_img [frb_pkg::RING_BYTES];
    int          rd_pos;
    int          wr_pos;
    logic [7:0]  cur_start;

    frame_cmd_t  frames_pending [$];
    beat_t       beats_due [$];

    logic        item_taken;
    int          send_idle_pct;
    int          stall_pct;
    int          stuck_cycles;
    int          errors;
    int          n_cmds;
    int          n_beats;
    int          n_full;
    int          n_empty;
    int          n_nohdr;
    int          n_cfg;
    logic        timed_out;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void ring_predict(logic act, logic [63:0] lo, logic [31:0] hi);
        logic [95:0] frame;
        int          room;
        int          i;
        frame = {hi, lo};
        if (act == frb_pkg::ACT_PUSH)
        begin
            room = (rd_pos + frb_pkg::RING_BYTES - wr_pos) % frb_pkg::RING_BYTES;
            if (rd_pos != wr_pos && room <= frb_pkg::FRAME_BYTES + 1)
            begin
                beats_due.push_back('{frb_pkg::ST_PUSH_FULL, 8'h00, 1'b1});
                n_full++;
            end
            else
            begin
                for (i = 0; i < frb_pkg::FRAME_BYTES; i++)
                    ring_img[(wr_pos + i) % frb_pkg::RING_BYTES] = frame[8*i +: 8];
                wr_pos = (wr_pos + frb_pkg::FRAME_BYTES) % frb_pkg::RING_BYTES;
                beats_due.push_back('{frb_pkg::ST_PUSH_OK, 8'h00, 1'b1});
            end
        end
        else if (rd_pos == wr_pos)
        begin
            beats_due.push_back('{frb_pkg::ST_PULL_EMPTY, 8'h00, 1'b1});
            n_empty++;
        end
        else if (ring_img[rd_pos] != cur_start ||
                 ring_img[(rd_pos + 1) % frb_pkg::RING_BYTES] != cur_start)
        begin
            beats_due.push_back('{frb_pkg::ST_PULL_NOHDR, 8'h00, 1'b1});
            n_nohdr++;
        end
        else
        begin
            for (i = 0; i < frb_pkg::FRAME_BYTES; i++)
                beats_due.push_back('{frb_pkg::ST_BYTE,
                                      ring_img[(rd_pos + i) % frb_pkg::RING_BYTES],
                                      (i == frb_pkg::FRAME_BYTES - 1)});
            rd_pos = (rd_pos + frb_pkg::FRAME_BYTES) % frb_pkg::RING_BYTES;
        end
    endfunction

    function automatic void add_cmd(logic act, logic [63:0] lo, logic [31:0] hi);
        frame_cmd_t c;
        c.act = act;
        c.lo  = lo;
        c.hi  = hi;
        frames_pending.push_back(c);
    endfunction

    // mostly frames headed by the current start byte, some with a foreign header
    function automatic void add_random_cmds(int count, int push_pct);
        logic [63:0] lo;
        logic [7:0]  hdr;
        int          k;
        for (k = 0; k < count; k++)
        begin
            lo  = {$urandom, $urandom};
            hdr = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : cur_start;
            if ($urandom_range(99) < push_pct)
            begin
                lo[15:0] = {hdr, hdr};
                add_cmd(frb_pkg::ACT_PUSH, lo, $urandom);
            end
            else
                add_cmd(frb_pkg::ACT_PULL, lo, $urandom);
        end
    endfunction

    task automatic wait_idle();
        while (frames_pending.size() != 0 || item_valid || beats_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_start_byte(input logic [7:0] value);
        logic [31:0] rd;
        wait_idle();
        repeat (4) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= frb_pkg::CFG_START_BYTE_ADDR;
        pwdata  <= {24'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[7:0] !== value)
        begin
            errors++;
            $display("%0t start_byte readback: expected %02h, got %02h", $time, value,
                     rd[7:0]);
        end
        cur_start = value;
        n_cfg++;
    endtask

    // recover a blocked head by matching its header, else take the fallback
    task automatic retarget_start(input logic [7:0] fallback);
        wait_idle();
        set_start_byte((rd_pos != wr_pos) ? ring_img[rd_pos] : fallback);
    endtask

    always @(negedge clk)
    begin
        frame_cmd_t c;
        if (rst_n && (!item_valid || item_taken))
        begin
            if (frames_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                c = frames_pending.pop_front();
                item_valid <= 1'b1;
                action     <= c.act;
                frame_lo   <= c.lo;
                frame_hi   <= c.hi;
            end
            else
                item_valid <= 1'b0;
        end
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        beat_t exp_beat;
        logic  cmd_fire;
        logic  beat_fire;
        cmd_fire  = rst_n && item_valid && !item_stall;
        beat_fire = rst_n && result_valid && !result_stall;
        item_taken <= cmd_fire;
        if (cmd_fire)
        begin
            ring_predict(action, frame_lo, frame_hi);
            n_cmds++;
        end
        if (beat_fire)
        begin
            n_beats++;
            if (beats_due.size() == 0)
            begin
                errors++;
                $display("%0t unexpected beat: expected none, got status=%0d byte=%02h last=%0b",
                         $time, status, data_byte, last);
            end
            else
            begin
                exp_beat = beats_due.pop_front();
                if (status !== exp_beat.st || data_byte !== exp_beat.db ||
                    last !== exp_beat.last)
                begin
                    errors++;
                    $display("%0t beat mismatch: expected status=%0d byte=%02h last=%0b,",
                             $time, exp_beat.st, exp_beat.db, exp_beat.last);
                    $display("%0t     got status=%0d byte=%02h last=%0b",
                             $time, status, data_byte, last);
                end
            end
        end
        stuck_cycles <= (cmd_fire || beat_fire) ? 0 : stuck_cycles + 1;
    end

    task automatic run_all();
        int          p;
        int          held;
        logic [63:0] lo;
        int          idle_tbl [PHASES] = '{0, 74, 0, 16, 0};
        int          stall_tbl [PHASES] = '{0, 0, 74, 16, 0};
        int          push_tbl [PHASES] = '{75, 40, 60, 50, 80};
        logic [7:0]  fallback_tbl [PHASES] = '{8'hFF, 8'h00, 8'h3C, 8'hFF, 8'h81};

        // directed: empty pull, extreme frames, a foreign header blocking the head
        add_cmd(frb_pkg::ACT_PULL, '0, '0);
        add_cmd(frb_pkg::ACT_PUSH, 64'hFFFF_FFFF_FFFF_0000, 32'hFFFF_FFFF);
        add_cmd(frb_pkg::ACT_PULL, '1, '1);
        add_cmd(frb_pkg::ACT_PUSH, '0, '0);
        add_cmd(frb_pkg::ACT_PULL, '0, '0);
        add_cmd(frb_pkg::ACT_PUSH, 64'h0123_4567_89AB_A5A5, 32'hDEAD_BEEF);
        add_cmd(frb_pkg::ACT_PUSH, 64'h7654_3210_FEDC_0000, 32'h0000_FFFF);
        add_cmd(frb_pkg::ACT_PULL, '0, '0);
        add_cmd(frb_pkg::ACT_PULL, '0, '0);
        retarget_start(8'h00);
        add_cmd(frb_pkg::ACT_PULL, '0, '0);
        add_cmd(frb_pkg::ACT_PULL, '0, '0);
        retarget_start(8'hFF);
        add_cmd(frb_pkg::ACT_PULL, '0, '0);
        add_cmd(frb_pkg::ACT_PULL, '0, '0);
        retarget_start(8'hFF);
        add_cmd(frb_pkg::ACT_PUSH, '1, '1);
        add_cmd(frb_pkg::ACT_PULL, '0, '0);
        add_cmd(frb_pkg::ACT_PULL, '0, '0);

        for (p = 0; p < PHASES; p++)
        begin
            retarget_start(fallback_tbl[p]);
            send_idle_pct = idle_tbl[p];
            stall_pct     = stall_tbl[p];
            add_random_cmds(68, push_tbl[p]);
        end

        // empty the ring, then block it with a frame whose second header byte is wrong
        send_idle_pct = 0;
        stall_pct     = 30;
        wait_idle();
        while (rd_pos != wr_pos)
        begin
            set_start_byte(ring_img[rd_pos]);
            held = ((wr_pos - rd_pos + frb_pkg::RING_BYTES) % frb_pkg::RING_BYTES)
                   / frb_pkg::FRAME_BYTES;
            repeat (held) add_cmd(frb_pkg::ACT_PULL, {$urandom, $urandom}, $urandom);
            wait_idle();
        end
        lo = {$urandom, $urandom};
        lo[15:0] = {~cur_start, cur_start};
        add_cmd(frb_pkg::ACT_PULL, '0, '0);
        add_cmd(frb_pkg::ACT_PUSH, lo, $urandom);
        add_cmd(frb_pkg::ACT_PULL, '0, '0);
        lo[15:0] = {cur_start, cur_start};
        add_cmd(frb_pkg::ACT_PUSH, lo, $urandom);
        add_cmd(frb_pkg::ACT_PULL, '0, '0);
        wait_idle();
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        item_valid    = 1'b0;
        action        = frb_pkg::ACT_PUSH;
        frame_lo      = '0;
        frame_hi      = '0;
        result_stall  = 1'b0;
        item_taken    = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        stuck_cycles  = 0;
        errors        = 0;
        n_cmds        = 0;
        n_beats       = 0;
        n_full        = 0;
        n_empty       = 0;
        n_nohdr       = 0;
        n_cfg         = 0;
        timed_out     = 1'b0;
        rd_pos        = 0;
        wr_pos        = 0;
        cur_start     = 8'h00;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        fork
            run_all();
            begin
                while (stuck_cycles < STUCK_LIMIT)
                    @(posedge clk);
                timed_out = 1'b1;
            end
        join_any

        if (beats_due.size() != 0)
        begin
            errors++;
            $display("%0t missing beats: expected %0d more, got none", $time,
                     beats_due.size());
        end
        $display("Ran %0d frame commands, checked %0d result beats, %0d start_byte settings.",
                 n_cmds, n_beats, n_cfg);
        $display("Seen: %0d full rejects, %0d empty pulls, %0d header refusals, timeout=%0b.",
                 n_full, n_empty, n_nohdr, timed_out);
        if (errors == 0 && !timed_out)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: frame_ring_buffer.f
rtl/core/frb_pkg.sv
rtl/core/frb_ram.sv
rtl/core/frb_ptr_add.sv
rtl/core/frb_ctrl.sv
rtl/core/frame_ring_buffer.sv
sim/tb_frame_ring_buffer.sv
